// ----- hw/rtl/sparse_int8_row_dot_product_macros.svh -----
// Assertion macros for the sparse int8 row dot product block.
// Used by the top level only; no other dependencies.
`ifndef SPARSE_INT8_ROW_DOT_PRODUCT_MACROS_SVH
`define SPARSE_INT8_ROW_DOT_PRODUCT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SRDP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define SRDP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/srdp_pkg.sv -----
// Package for the sparse int8 row dot product block.
// Function codes, shared constants and controller/datapath structs.
`timescale 1ns / 1ps

package srdp_pkg;

    localparam int ROW_DEPTH_DEFAULT = 4096;
    localparam int GROUP_SIZE        = 16;
    localparam int GROUP_POS_W       = $clog2(GROUP_SIZE);
    localparam int ROW_ADDR_W        = 12;
    localparam int GATHER_ADDR_W     = 18;

    typedef enum logic [1:0] {
        FUNC_WRITE  = 2'd0,
        FUNC_SPARSE = 2'd1,
        FUNC_FINISH = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    typedef struct packed {
        logic row_write;
        logic capture;
        logic gather;
        logic mac;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
    } t_dp_status;

endpackage

// ----- hw/rtl/srdp_datapath.sv -----
// Datapath: row store memory, group base tracking, gather and MAC.
// Depends on srdp_pkg; driven by srdp_ctrl commands.
`timescale 1ns / 1ps

module srdp_datapath #(
    parameter int ROW_DEPTH = srdp_pkg::ROW_DEPTH_DEFAULT
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  srdp_pkg::t_dp_cmd                      i_cmd,
    output srdp_pkg::t_dp_status                   o_status,
    input  logic [srdp_pkg::ROW_ADDR_W-1:0]        i_row_addr,
    input  logic signed [7:0]                      i_row_value,
    input  logic signed [7:0]                      i_sparse_value,
    input  logic [7:0]                             i_sparse_index,
    input  logic signed [15:0]                     i_group_offset,
    input  logic                                   i_last,
    output logic signed [31:0]                     o_dot_result,
    output logic                                   o_addr_error
);
    import srdp_pkg::*;

    localparam int AW = $clog2(ROW_DEPTH);
    localparam logic [GATHER_ADDR_W-1:0] DepthL = GATHER_ADDR_W'(ROW_DEPTH);

    logic signed [7:0]        r_mem [ROW_DEPTH];
    logic signed [7:0]        r_value;
    logic [7:0]               r_index;
    logic                     r_last;
    logic signed [7:0]        r_entry;
    logic                     r_oob;
    logic [16:0]              r_base;
    logic [GROUP_POS_W-1:0]   r_pos;
    logic [31:0]              r_acc;
    logic                     r_err;

    logic [GATHER_ADDR_W-1:0] wr_addr;
    logic                     wr_ok;
    logic [GATHER_ADDR_W-1:0] rd_addr;
    logic                     rd_ok;
    logic signed [7:0]        entry_m;
    logic signed [15:0]       prod;

    assign wr_addr = {{(GATHER_ADDR_W - ROW_ADDR_W){1'b0}}, i_row_addr};
    assign wr_ok   = (wr_addr < DepthL);
    assign rd_addr = {r_base[16], r_base} + {{(GATHER_ADDR_W - 8){1'b0}}, r_index};
    assign rd_ok   = !rd_addr[GATHER_ADDR_W-1] && (rd_addr < DepthL);
    assign entry_m = r_oob ? 8'sd0 : r_entry;
    assign prod    = r_value * entry_m;
    assign o_status.last = r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_write && wr_ok) begin
            r_mem[wr_addr[AW-1:0]] <= i_row_value;
        end
        if (i_cmd.gather && rd_ok) begin
            r_entry <= r_mem[rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_value <= i_sparse_value;
            r_index <= i_sparse_index;
            r_last  <= i_last;
        end
        if (i_cmd.gather) begin
            r_oob <= !rd_ok;
        end
        if (i_cmd.emit) begin
            o_dot_result <= r_acc;
            o_addr_error <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_pos  <= '0;
            r_acc  <= '0;
            r_err  <= 1'b0;
        end else if (i_cmd.emit) begin
            r_base <= '0;
            r_pos  <= '0;
            r_acc  <= '0;
            r_err  <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                if (r_pos == '0) begin
                    r_base <= r_base + {i_group_offset[15], i_group_offset};
                end
                r_pos <= r_pos + 1'b1;
            end
            if (i_cmd.mac) begin
                r_acc <= r_acc + {{16{prod[15]}}, prod};
                r_err <= r_err | r_oob;
            end
        end
    end

endmodule

// ----- hw/rtl/srdp_ctrl.sv -----
// Controller: sequences capture, gather, MAC and result emission.
// Depends on srdp_pkg; commands srdp_datapath.
`timescale 1ns / 1ps

module srdp_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_func,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output srdp_pkg::t_dp_cmd     o_cmd,
    input  srdp_pkg::t_dp_status  i_status
);
    import srdp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GATHER,
        ST_MAC,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    t_func  func;
    logic   accept;

    assign func        = t_func'(i_func);
    assign o_in_ready  = (r_state == ST_IDLE);
    assign accept      = o_in_ready && i_in_valid;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.row_write = accept && (func == FUNC_WRITE);
        o_cmd.capture   = accept && (func == FUNC_SPARSE);
        o_cmd.gather    = (r_state == ST_GATHER);
        o_cmd.mac       = (r_state == ST_MAC);
        o_cmd.emit      = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (func)
                        FUNC_SPARSE: n_state = ST_GATHER;
                        FUNC_FINISH: n_state = ST_EMIT;
                        FUNC_WRITE,
                        FUNC_NOP:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_GATHER: n_state = ST_MAC;
            ST_MAC:    n_state = i_status.last ? ST_EMIT : ST_IDLE;
            ST_EMIT: begin
                if (o_cmd.emit) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- hw/rtl/sparse_int8_row_dot_product.sv -----
// Sparse int8 row dot product. A dense row of signed 8-bit entries is written
// into an on-chip row store (func 0); sparse elements (func 1) each go through
// three steps: capture with group base update, a registered row store read,
// and an 8x8 multiply-accumulate. After the element marked last, and on func 2,
// an emit state loads the result register. Row writes and func 3 complete when
// accepted. The single row store read port and the controller sequence set
// this order. The result register lets the next transaction be accepted
// while a result waits; a new result waits only if the previous one is untaken.
// Depends on srdp_pkg, srdp_ctrl, srdp_datapath and the assertion macro header.
`timescale 1ns / 1ps

module sparse_int8_row_dot_product #(
    parameter int ROW_DEPTH = srdp_pkg::ROW_DEPTH_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_func,
    input  logic [srdp_pkg::ROW_ADDR_W-1:0]     i_row_addr,
    input  logic signed [7:0]                   i_row_value,
    input  logic signed [7:0]                   i_sparse_value,
    input  logic [7:0]                          i_sparse_index,
    input  logic signed [15:0]                  i_group_offset,
    input  logic                                i_last,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [31:0]                  o_dot_result,
    output logic                                o_addr_error
);
    import srdp_pkg::*;

    `include "sparse_int8_row_dot_product_macros.svh"

    t_dp_cmd    cmd;
    t_dp_status status;

    srdp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .i_func      (i_func),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    srdp_datapath #(
        .ROW_DEPTH (ROW_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_row_addr     (i_row_addr),
        .i_row_value    (i_row_value),
        .i_sparse_value (i_sparse_value),
        .i_sparse_index (i_sparse_index),
        .i_group_offset (i_group_offset),
        .i_last         (i_last),
        .o_dot_result   (o_dot_result),
        .o_addr_error   (o_addr_error)
    );

    `SRDP_ASSERT_IMP(a_cmd_onehot, i_clk, i_rst_n, 1'b1, $onehot0({cmd.capture, cmd.gather, cmd.mac, cmd.emit}), "overlapping datapath commands")
    `SRDP_ASSERT_NXT(a_capture_gather, i_clk, i_rst_n, cmd.capture, cmd.gather && !o_ready, "capture not followed by gather")
    `SRDP_ASSERT_NXT(a_gather_mac, i_clk, i_rst_n, cmd.gather, cmd.mac, "gather not followed by MAC")
    `SRDP_ASSERT_NXT(a_emit_valid, i_clk, i_rst_n, cmd.emit, o_valid && o_ready, "emit did not present a result")

endmodule

// ----- tb/tb_sparse_int8_row_dot_product.sv -----
// Testbench for sparse_int8_row_dot_product: valid/ready driver and monitor,
// in-bench predictor of the gather/multiply-accumulate, result check in order.
// Depends on srdp_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_sparse_int8_row_dot_product;
    import srdp_pkg::*;

    localparam int ROW_DEPTH    = ROW_DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 600;
    localparam int TAIL_ITEMS   = 100;
    localparam int CYCLE_LIMIT  = 800_000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        t_func              func;
        logic [11:0]        row_addr;
        logic signed [7:0]  row_value;
        logic signed [7:0]  sparse_value;
        logic [7:0]         sparse_index;
        logic signed [15:0] group_offset;
        logic               last;
    } t_dot_item;

    typedef struct packed {
        logic [31:0] dot;
        logic        err;
    } t_dot_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [1:0]          i_func = '0;
    logic [11:0]         i_row_addr = '0;
    logic signed [7:0]   i_row_value = '0;
    logic signed [7:0]   i_sparse_value = '0;
    logic [7:0]          i_sparse_index = '0;
    logic signed [15:0]  i_group_offset = '0;
    logic                i_last = 1'b0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic signed [31:0]  o_dot_result;
    logic                o_addr_error;

    sparse_int8_row_dot_product #(
        .ROW_DEPTH(ROW_DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_row_addr     (i_row_addr),
        .i_row_value    (i_row_value),
        .i_sparse_value (i_sparse_value),
        .i_sparse_index (i_sparse_index),
        .i_group_offset (i_group_offset),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_dot_result   (o_dot_result),
        .o_addr_error   (o_addr_error)
    );

    t_dot_item   pending_items[$];
    t_dot_result expected_dots[$];
    t_dot_item   next_item;
    int          total_items;
    int          useful_items;
    int          accepted_count;
    int          cycle_count;
    int          mismatch_count;
    int          send_gap;
    int          recv_gap;

    // stimulus-side tracking of the group base and of written entries;
    // every in-range gather reads an entry written earlier
    logic signed [16:0] gen_base;
    logic [3:0]         gen_pos;
    bit                 gen_written [ROW_DEPTH];

    // predictor state
    logic signed [7:0]  model_row [ROW_DEPTH];
    logic [31:0]        model_acc;
    logic signed [16:0] model_base;
    logic [3:0]         model_pos;
    logic               model_err;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit idle_allowed();
        return pending_items.size() >= TAIL_ITEMS && cycle_count[10:9] != 2'b11;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic push_item(input t_func f, input logic [11:0] addr,
                             input logic signed [7:0] rv, input logic signed [7:0] sv,
                             input logic [7:0] idx, input logic signed [15:0] off,
                             input logic lst);
        t_dot_item it;
        it.func         = f;
        it.row_addr     = addr;
        it.row_value    = rv;
        it.sparse_value = sv;
        it.sparse_index = idx;
        it.group_offset = off;
        it.last         = lst;
        pending_items.push_back(it);
        if (f != FUNC_NOP)
            useful_items++;
        if (f == FUNC_WRITE && addr < ROW_DEPTH)
            gen_written[addr] = 1'b1;
        if (f == FUNC_SPARSE) begin
            if (gen_pos == 0)
                gen_base = gen_base + off;
            gen_pos = gen_pos + 1'b1;
        end
        if (f == FUNC_FINISH || (f == FUNC_SPARSE && lst)) begin
            gen_base = '0;
            gen_pos  = '0;
        end
    endtask

    task automatic push_write(input logic [11:0] addr, input logic signed [7:0] val);
        push_item(FUNC_WRITE, addr, val, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic push_ctrl(input t_func f);
        push_item(f, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // an in-range entry not yet written gets a write just before the gather
    task automatic push_element(input logic signed [7:0] sv, input logic [7:0] idx,
                                input logic signed [15:0] off, input logic lst);
        logic signed [16:0] base;
        int                 gaddr;
        base = (gen_pos == 0) ? gen_base + off : gen_base;
        gaddr = base;
        gaddr = gaddr + int'(idx);
        if (gaddr >= 0 && gaddr < ROW_DEPTH && !gen_written[gaddr])
            push_write(gaddr[11:0], $urandom);
        push_item(FUNC_SPARSE, $urandom, $urandom, sv, idx, off, lst);
    endtask

    // One compressed row; wrap rows use extreme offsets so the base overflows.
    task automatic push_random_row(input bit wrap_row);
        int                 len;
        int                 target;
        bit                 abort;
        bit                 downward;
        logic signed [15:0] off;
        len = wrap_row ? $urandom_range(33, 40)
            : ($urandom_range(0, 3) == 0 ? $urandom_range(17, 40) : $urandom_range(1, 16));
        abort    = ($urandom_range(0, 9) == 0);
        downward = $urandom_range(0, 1);
        for (int n = 0; n < len; n++) begin
            if ($urandom_range(0, 19) == 0) begin
                if ($urandom_range(0, 1))
                    push_write($urandom, $urandom);
                else
                    push_ctrl(FUNC_NOP);
            end
            if (gen_pos != 0) begin
                off = $urandom;
            end else if (wrap_row) begin
                off = downward ? 16'h8000 : 16'h7FFF;
            end else if ($urandom_range(0, 9) == 0) begin
                off = $urandom;
            end else begin
                target = int'($urandom_range(0, 3960)) - 40;
                off = target - gen_base;
            end
            push_element($urandom, $urandom_range(0, 255), off, (n == len - 1) && !abort);
        end
        if (abort)
            push_ctrl(FUNC_FINISH);
    endtask

    task automatic emit_dot();
        t_dot_result r;
        r.dot = model_acc;
        r.err = model_err;
        expected_dots.push_back(r);
        model_acc  = '0;
        model_base = '0;
        model_pos  = '0;
        model_err  = 1'b0;
    endtask

    task automatic predict_dot(input t_dot_item it);
        int                 gaddr;
        logic signed [7:0]  entry;
        logic signed [15:0] prod;
        case (it.func)
            FUNC_WRITE: begin
                if (it.row_addr < ROW_DEPTH)
                    model_row[it.row_addr] = it.row_value;
            end
            FUNC_FINISH: emit_dot();
            FUNC_SPARSE: begin
                if (model_pos == 0)
                    model_base = model_base + it.group_offset;
                model_pos = model_pos + 1'b1;
                gaddr = model_base;
                gaddr = gaddr + int'(it.sparse_index);
                if (gaddr < 0 || gaddr >= ROW_DEPTH) begin
                    model_err = 1'b1;
                    entry = '0;
                end else begin
                    entry = model_row[gaddr];
                end
                prod = it.sparse_value * entry;
                model_acc = model_acc + {{16{prod[15]}}, prod};
                if (it.last)
                    emit_dot();
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap <= 0;
        end else if (!i_valid || o_ready) begin
            if (idle_allowed() && send_gap != 0) begin
                i_valid  <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (idle_allowed() && $urandom_range(0, 9) == 0) begin
                i_valid  <= 1'b0;
                send_gap <= $urandom_range(0, 13);
            end else if (pending_items.size() == 0) begin
                i_valid <= 1'b0;
            end else begin
                next_item = pending_items.pop_front();
                i_valid        <= 1'b1;
                i_func         <= next_item.func;
                i_row_addr     <= next_item.row_addr;
                i_row_value    <= next_item.row_value;
                i_sparse_value <= next_item.sparse_value;
                i_sparse_index <= next_item.sparse_index;
                i_group_offset <= next_item.group_offset;
                i_last         <= next_item.last;
                send_gap       <= 0;
            end
        end
    end

    always @(posedge i_clk) begin : watch_inputs
        t_dot_item seen;
        if (i_rst_n && i_valid && o_ready) begin
            seen.func         = t_func'(i_func);
            seen.row_addr     = i_row_addr;
            seen.row_value    = i_row_value;
            seen.sparse_value = i_sparse_value;
            seen.sparse_index = i_sparse_index;
            seen.group_offset = i_group_offset;
            seen.last         = i_last;
            predict_dot(seen);
            accepted_count <= accepted_count + 1;
        end
    end

    always @(posedge i_clk) begin : watch_results
        t_dot_result want;
        if (!i_rst_n) begin
            i_ready  <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_dots.size() == 0) begin
                    flag_mismatch($sformatf("unexpected transaction dot=%0d err=%0b",
                                            o_dot_result, o_addr_error));
                end else begin
                    want = expected_dots.pop_front();
                    if (o_dot_result !== want.dot)
                        flag_mismatch($sformatf("dot_result %0d, want %0d",
                                                o_dot_result, $signed(want.dot)));
                    if (o_addr_error !== want.err)
                        flag_mismatch($sformatf("addr_error %0b, want %0b",
                                                o_addr_error, want.err));
                end
            end
            if (idle_allowed() && recv_gap != 0) begin
                i_ready  <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else if (idle_allowed() && $urandom_range(0, 9) == 0) begin
                i_ready  <= 1'b0;
                recv_gap <= $urandom_range(0, 13);
            end else begin
                i_ready  <= 1'b1;
                recv_gap <= 0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout: %0d of %0d transactions accepted, %0d results outstanding",
                     accepted_count, total_items, expected_dots.size());
            $display("sparse_int8_row_dot_product test failed");
            $finish;
        end
    end

    initial begin
        int start_count;
        int r;
        gen_base   = '0;
        gen_pos    = '0;
        model_acc  = '0;
        model_base = '0;
        model_pos  = '0;
        model_err  = 1'b0;
        for (int a = 0; a < ROW_DEPTH; a++)
            model_row[a] = '0;

        push_ctrl(FUNC_FINISH);                       // empty row
        push_ctrl(FUNC_NOP);
        push_write(12'd0, 8'h80);
        push_write(12'hFFF, 8'h7F);
        push_write(12'd255, 8'h80);
        push_element(8'h80, 8'd0, 16'h0000, 1'b0);
        push_element(8'h7F, 8'd255, 16'h7FFF, 1'b1);  // offset ignored mid-group
        push_element(8'h7F, 8'd255, 16'sd3840, 1'b1); // top entry
        push_element(8'h05, 8'd0, 16'hFFFF, 1'b0);    // below the store
        push_element(8'h80, 8'd255, 16'h7FFF, 1'b1);  // error flag sticks
        push_element(8'h01, 8'd1, 16'sd4095, 1'b1);   // one past the top
        push_element(8'h7F, 8'd255, 16'h7FFF, 1'b1);
        push_element(8'h80, 8'd255, 16'h8000, 1'b1);
        push_element(8'hFF, 8'd10, 16'sd100, 1'b0);
        push_ctrl(FUNC_FINISH);                       // flush unfinished row
        push_ctrl(FUNC_FINISH);

        start_count = useful_items;
        while (useful_items < start_count + RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 6)
                push_write($urandom, $urandom);
            else if (r < 10)
                push_ctrl(FUNC_NOP);
            else if (r < 14)
                push_ctrl(FUNC_FINISH);
            else
                push_random_row(r < 22);
        end
        total_items = pending_items.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total_items)
            @(posedge i_clk);
        while (expected_dots.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_dots.size() == 0)
            $display("sparse_int8_row_dot_product test passed");
        else
            $display("sparse_int8_row_dot_product test failed");
        $finish;
    end

endmodule
